### design/tdbs_pkg.sv
// Shared constants, types and helpers for the temporal difference box-sum filter.
// Used by the stream interfaces, the emitter and the top level.
package tdbs_pkg;

   // sample and result field widths
   localparam int unsigned PIX_W     = 8;
   localparam int unsigned OUT_COL_W = 11;
   localparam int unsigned OUT_ROW_W = 12;

   // configuration port
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 13;
   localparam int unsigned FRAME_WIDTH_W  = 12;
   localparam int unsigned FRAME_HEIGHT_W = 13;
   localparam int unsigned FRAME_WIDTH_RST  = 640;
   localparam int unsigned FRAME_HEIGHT_RST = 480;
   localparam int unsigned MIN_SIZE = 3;

   // default size limits for the top level
   localparam int unsigned DEF_MAX_WIDTH  = 2048;
   localparam int unsigned DEF_MAX_HEIGHT = 4096;

   // arithmetic widths
   localparam int unsigned DIFF_W  = PIX_W + 1;   // new - old
   localparam int unsigned CS_W    = DIFF_W + 2;  // sum of three lines
   localparam int unsigned WIN_W   = CS_W + 2;    // sum of three columns
   localparam int unsigned BIAS_W  = WIN_W + 1;   // window plus offset, non-negative
   localparam int unsigned HALF_W  = BIAS_W - 2;  // (window + offset) / 2
   localparam int unsigned NCHAN   = 3;
   localparam int unsigned LINE_W  = NCHAN * DIFF_W;

   // (win + 2295) / 18 == ((win + 2295) >> 1) / 9 ; /9 by reciprocal 7282 / 2^16
   localparam int unsigned DIFF_OFFSET = 2295;
   localparam int unsigned RECIP_NINE  = 7282;
   localparam int unsigned RECIP_W     = 13;
   localparam int unsigned RECIP_SHIFT = 16;
   localparam int unsigned PROD_W      = HALF_W + RECIP_W;

   // per-item result list, emitted lowest bit first
   localparam int unsigned EMIT_W = 4;
   localparam logic [EMIT_W-1:0] EMIT_LEFT  = 4'b0001; // zero at (0, row-1)
   localparam logic [EMIT_W-1:0] EMIT_WIN   = 4'b0010; // window at (col-1, row-1)
   localparam logic [EMIT_W-1:0] EMIT_RIGHT = 4'b0100; // zero at (col, row-1)
   localparam logic [EMIT_W-1:0] EMIT_HERE  = 4'b1000; // zero at (col, row)

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [NCHAN-1:0][DIFF_W-1:0] diff_vec_type;
   typedef logic [NCHAN-1:0][HALF_W-1:0] half_vec_type;

   // one item handed from the window stage to the emitter
   typedef struct packed {
      logic [EMIT_W-1:0]    emit_mask;
      logic [OUT_COL_W-1:0] col;
      logic [OUT_COL_W-1:0] col_prev;
      logic [OUT_ROW_W-1:0] row;
      logic [OUT_ROW_W-1:0] row_prev;
      half_vec_type         half_sum;
   } item_type;

   // last index of a frame dimension, sizes below three act as three
   function automatic int unsigned size_last(int unsigned v, int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE - 1;
      if (v > hi) return hi - 1;
      return v - 1;
   endfunction

endpackage

### design/tdbs_req_if.sv
// Input stream interface: new and old frame samples with valid/ready.
// Depends on tdbs_pkg for field widths.
interface tdbs_req_if import tdbs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] new_red;
   logic [PIX_W-1:0] new_green;
   logic [PIX_W-1:0] new_blue;
   logic [PIX_W-1:0] old_red;
   logic [PIX_W-1:0] old_green;
   logic [PIX_W-1:0] old_blue;

   modport source (output valid, new_red, new_green, new_blue,
                   output old_red, old_green, old_blue, input ready);
   modport sink   (input valid, new_red, new_green, new_blue,
                   input old_red, old_green, old_blue, output ready);
endinterface

### design/tdbs_rsp_if.sv
// Result stream interface: filtered pixel, its position and the run end flag.
// Depends on tdbs_pkg for field widths.
interface tdbs_rsp_if import tdbs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PIX_W-1:0]     out_red;
   logic [PIX_W-1:0]     out_green;
   logic [PIX_W-1:0]     out_blue;
   logic [OUT_COL_W-1:0] out_col;
   logic [OUT_ROW_W-1:0] out_row;
   logic                 run_last;

   modport source (output valid, out_red, out_green, out_blue,
                   output out_col, out_row, run_last, input ready);
   modport sink   (input valid, out_red, out_green, out_blue,
                   input out_col, out_row, run_last, output ready);
endinterface

### design/tdbs_emitter.sv
// Result stage: holds one item, issues its results one per transfer, scales
// the window sums by 1/9 and drives the output register. Depends on tdbs_pkg.
module tdbs_emitter import tdbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  item_type   item,
   output logic       free,
   tdbs_rsp_if.source rsp_chan
);

   logic              s2_valid_ff, s2_valid_in;
   logic [EMIT_W-1:0] mask_ff, mask_in;
   item_type          item_ff;
   logic              out_valid_ff, out_valid_in;

   logic [EMIT_W-1:0] pick, rest;
   logic              out_load, emit;
   logic [NCHAN-1:0][PIX_W-1:0] scaled;
   logic [NCHAN-1:0][PROD_W-1:0] prod;

   logic [NCHAN-1:0][PIX_W-1:0] val_ff, val_in;
   logic [OUT_COL_W-1:0] col_ff, col_in;
   logic [OUT_ROW_W-1:0] row_ff, row_in;
   logic                 last_ff;

   assign out_load = !out_valid_ff || rsp_chan.ready;
   assign pick     = mask_ff & (~mask_ff + EMIT_W'(1));
   assign rest     = mask_ff & ~pick;
   assign emit     = s2_valid_ff && (mask_ff != '0) && out_load;
   assign free     = !s2_valid_ff || (mask_ff == '0) || (emit && (rest == '0));

   // divide by nine through the reciprocal
   always_comb begin
      for (int ch = 0; ch < NCHAN; ch++) begin
         prod[ch]   = PROD_W'(item_ff.half_sum[ch]) * PROD_W'(RECIP_NINE);
         scaled[ch] = prod[ch][RECIP_SHIFT +: PIX_W];
      end
   end

   always_comb begin
      val_in = '0;
      col_in = item_ff.col;
      row_in = item_ff.row;
      case (pick)
         EMIT_LEFT: begin
            col_in = '0;
            row_in = item_ff.row_prev;
         end
         EMIT_WIN: begin
            val_in = scaled;
            col_in = item_ff.col_prev;
            row_in = item_ff.row_prev;
         end
         EMIT_RIGHT: begin
            row_in = item_ff.row_prev;
         end
         EMIT_HERE: begin
            row_in = item_ff.row;
         end
         default: begin
            val_in = '0;
         end
      endcase
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      mask_in     = mask_ff;
      if (load) begin
         s2_valid_in = 1'b1;
         mask_in     = item.emit_mask;
      end else if (free) begin
         s2_valid_in = 1'b0;
         mask_in     = '0;
      end else if (emit) begin
         mask_in = rest;
      end
      out_valid_in = emit ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
      if (emit) begin
         val_ff  <= val_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         last_ff <= (rest == '0);
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.out_red   = val_ff[0];
   assign rsp_chan.out_green = val_ff[1];
   assign rsp_chan.out_blue  = val_ff[2];
   assign rsp_chan.out_col   = col_ff;
   assign rsp_chan.out_row   = row_ff;
   assign rsp_chan.run_last  = last_ff;

   // a column-one item never also carries a window result
   a_left_win_excl: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> !(((mask_ff & EMIT_LEFT) != '0) && ((mask_ff & EMIT_WIN) != '0)))
      else $error("left border and window result on one item");

   // a result that is not last leaves its item pending
   a_not_last_pending: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !last_ff) |-> (s2_valid_ff && (mask_ff != '0)))
      else $error("non-last result without pending item");

   // a partial emission keeps the item in place
   a_partial_holds: assert property (@(posedge clock) disable iff (reset)
      (emit && (rest != '0)) |=> (s2_valid_ff && (mask_ff == $past(rest))))
      else $error("partial emission lost remaining results");

endmodule

### design/temporal_diff_box_sum_filter.sv
// Temporal difference 3x3 box-sum filter, top level.
// Path: stage 1 registers, emitter item register, then output register to rsp_chan.
// Throughput: one input per cycle while rsp_chan takes results; inputs with two or
// three results (line ends, last row) hold req_chan while the single emitter issues them.
// Reset (synchronous, high): sizes to 640x480, position and column sums to zero.
// The line store is not cleared: rows zero and one may read unwritten entries but owe no window.
module temporal_diff_box_sum_filter import tdbs_pkg::*; #(
   parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   tdbs_req_if.sink              req_chan,
   tdbs_rsp_if.source            rsp_chan
);

   localparam int unsigned COL_W = $clog2(MAX_WIDTH);
   localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);

   // ---------------------------------------------------------------------
   // Configuration: the last column and last row index, already clamped.
   // Any write restarts the frame.
   // ---------------------------------------------------------------------
   logic [COL_W-1:0] w_last_ff, w_last_in;
   logic [ROW_W-1:0] h_last_ff, h_last_in;

   always_comb begin
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               w_last_in = COL_W'(size_last(32'(csr_wdata[FRAME_WIDTH_W-1:0]), MAX_WIDTH));
            end
            CSR_FRAME_HEIGHT: begin
               h_last_in = ROW_W'(size_last(32'(csr_wdata[FRAME_HEIGHT_W-1:0]),
                                            MAX_HEIGHT));
            end
            default: begin
               w_last_in = w_last_ff;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stage 0: position counters, result list, line store read.
   // ---------------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             accept;
   logic             row_zero, row_one, row_deep;
   logic [EMIT_W-1:0] mask_new;
   diff_vec_type     diff_new;

   // stage 1 registers
   logic              s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0]  s1_col_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [EMIT_W-1:0] s1_mask_ff;
   diff_vec_type      s1_diff_ff;
   logic              s1_free, s1_adv;
   logic              em_free;

   assign s1_adv  = s1_valid_ff && em_free;
   assign s1_free = !s1_valid_ff || em_free;
   assign accept  = req_chan.valid && s1_free;
   assign req_chan.ready = s1_free;

   assign row_zero = (row_ff == '0);
   assign row_one  = (row_ff == ROW_W'(1));
   assign row_deep = !row_zero && !row_one;

   // results owed by this position, in the order they leave
   always_comb begin
      mask_new = '0;
      if (row_deep && (col_ff == COL_W'(1))) mask_new = mask_new | EMIT_LEFT;
      if (row_deep && (col_ff > COL_W'(1)))  mask_new = mask_new | EMIT_WIN;
      if (row_deep && (col_ff == w_last_ff)) mask_new = mask_new | EMIT_RIGHT;
      if (row_zero || (row_deep && (row_ff == h_last_ff))) begin
         mask_new = mask_new | EMIT_HERE;
      end
   end

   assign diff_new[0] = {1'b0, req_chan.new_red}   - {1'b0, req_chan.old_red};
   assign diff_new[1] = {1'b0, req_chan.new_green} - {1'b0, req_chan.old_green};
   assign diff_new[2] = {1'b0, req_chan.new_blue}  - {1'b0, req_chan.old_blue};

   // raster position of the next input
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == w_last_ff) begin
            col_in = '0;
            row_in = (row_ff == h_last_ff) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Line store: entry per column holds {two lines up, one line up}.
   // Read at transfer, written back as {one line up, new} when the item
   // leaves stage 1.
   // Consecutive items hit distinct columns, so no forwarding is needed.
   // ---------------------------------------------------------------------
   logic [2*LINE_W-1:0] line_mem [MAX_WIDTH];
   logic [2*LINE_W-1:0] rd_ff;
   diff_vec_type        line_up2, line_up1;

   assign line_up2 = rd_ff[LINE_W +: LINE_W];
   assign line_up1 = rd_ff[0 +: LINE_W];

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         line_mem[s1_col_ff] <= {line_up1, s1_diff_ff};
      end
      if (accept) begin
         rd_ff <= line_mem[col_ff];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: column sum of three lines, window over three columns.
   // ---------------------------------------------------------------------
   logic signed [CS_W-1:0]   colsum0_ff [NCHAN];
   logic signed [CS_W-1:0]   colsum1_ff [NCHAN];
   logic signed [CS_W-1:0]   cs         [NCHAN];
   logic signed [WIN_W-1:0]  win        [NCHAN];
   logic signed [BIAS_W-1:0] biased     [NCHAN];
   half_vec_type             half_sum;
   item_type                 em_item;

   always_comb begin
      for (int ch = 0; ch < NCHAN; ch++) begin
         cs[ch]  = CS_W'($signed(line_up2[ch])) + CS_W'($signed(line_up1[ch]))
                 + CS_W'($signed(s1_diff_ff[ch]));
         win[ch] = WIN_W'(cs[ch]) + WIN_W'(colsum0_ff[ch]) + WIN_W'(colsum1_ff[ch]);
         biased[ch]   = BIAS_W'(win[ch]) + BIAS_W'(DIFF_OFFSET);
         half_sum[ch] = biased[ch][HALF_W:1];
      end
   end

   always_comb begin
      em_item.emit_mask = s1_mask_ff;
      em_item.col       = OUT_COL_W'(s1_col_ff);
      em_item.col_prev  = OUT_COL_W'(s1_col_ff - COL_W'(1));
      em_item.row       = OUT_ROW_W'(s1_row_ff);
      em_item.row_prev  = OUT_ROW_W'(s1_row_ff - ROW_W'(1));
      em_item.half_sum  = half_sum;
   end

   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff   <= COL_W'(size_last(FRAME_WIDTH_RST, MAX_WIDTH));
         h_last_ff   <= ROW_W'(size_last(FRAME_HEIGHT_RST, MAX_HEIGHT));
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         for (int ch = 0; ch < NCHAN; ch++) begin
            colsum0_ff[ch] <= '0;
            colsum1_ff[ch] <= '0;
         end
      end else begin
         w_last_ff   <= w_last_in;
         h_last_ff   <= h_last_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         if (csr_we) begin
            for (int ch = 0; ch < NCHAN; ch++) begin
               colsum0_ff[ch] <= '0;
               colsum1_ff[ch] <= '0;
            end
         end else if (s1_adv) begin
            for (int ch = 0; ch < NCHAN; ch++) begin
               colsum1_ff[ch] <= colsum0_ff[ch];
               colsum0_ff[ch] <= cs[ch];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
         s1_mask_ff <= mask_new;
         s1_diff_ff <= diff_new;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2 and output register.
   // ---------------------------------------------------------------------
   tdbs_emitter u_emitter (
      .clock    (clock),
      .reset    (reset),
      .load     (s1_adv),
      .item     (em_item),
      .free     (em_free),
      .rsp_chan (rsp_chan)
   );

   // the write-back and the new read never address the same column
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_adv) |-> (col_ff != s1_col_ff))
      else $error("line store read and write on one column");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= w_last_ff)
      else $error("column counter beyond line end");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      row_ff <= h_last_ff)
      else $error("row counter beyond frame end");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the temporal difference 3x3 box-sum filter: a stimulus
// table, then random frames in three idling phases, all results scoreboarded.
// Depends on tdbs_pkg, tdbs_req_if, tdbs_rsp_if and temporal_diff_box_sum_filter.
module tb_top import tdbs_pkg::*; ();

   // run control
   localparam int LIMIT_CYCLES     = 200_000;
   localparam int RESET_CYCLES     = 10;
   localparam int SETTLE_CYCLES    = 6;     // result path: stage 1, emitter and output registers
   localparam int RANDOM_PER_PHASE = 26;

   // window sum lies in -2295..2295; bias it up and divide by 18 for 0..255
   localparam int BOX_BIAS = 255 * 9;
   localparam int BOX_DIV  = 2 * 9;

   // idle percentages per phase: receiver-heavy, sender-heavy, none
   localparam int SEND_IDLE [3] = '{36, 55, 0};
   localparam int RECV_IDLE [3] = '{55, 36, 0};

   // one position of the newer and the older frame
   typedef struct packed {
      logic [PIX_W-1:0] new_red;
      logic [PIX_W-1:0] new_green;
      logic [PIX_W-1:0] new_blue;
      logic [PIX_W-1:0] old_red;
      logic [PIX_W-1:0] old_green;
      logic [PIX_W-1:0] old_blue;
   } pix_pair_type;

   // one filtered pixel as it leaves on rsp_chan
   typedef struct packed {
      logic [PIX_W-1:0]     red;
      logic [PIX_W-1:0]     green;
      logic [PIX_W-1:0]     blue;
      logic [OUT_COL_W-1:0] col;
      logic [OUT_ROW_W-1:0] row;
      logic                 last;
   } pixel_result_type;

   // results typed into the table by hand; typed low means use the predictor
   typedef struct packed {
      logic                       typed;
      logic [1:0]                 count;
      pixel_result_type [2:0]     res;
   } known_outcome_type;

   typedef enum logic {ROW_PIXEL, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      csr_index_type           csr_idx;
      logic [CSR_DATA_W-1:0]   csr_data;
      pix_pair_type            px;
      known_outcome_type       outcome;
   } stim_row_type;

   localparam pix_pair_type     PX_RISE  = {8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
   localparam pix_pair_type     PX_FALL  = {8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF};
   localparam pixel_result_type NO_PIXEL = '0;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tdbs_req_if req_chan ();
   tdbs_rsp_if rsp_chan ();

   temporal_diff_box_sum_filter #(
      .MAX_WIDTH  (DEF_MAX_WIDTH),
      .MAX_HEIGHT (DEF_MAX_HEIGHT)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor state: its own copy of sizes, line stores, column sums and
   // raster position, updated at the edge of every transfer or CSR write.
   // ---------------------------------------------------------------------
   logic [FRAME_WIDTH_W-1:0]  pred_width;
   logic [FRAME_HEIGHT_W-1:0] pred_height;
   logic signed [DIFF_W-1:0]  diff_two_up [DEF_MAX_WIDTH][NCHAN];  // line r-2
   logic signed [DIFF_W-1:0]  diff_one_up [DEF_MAX_WIDTH][NCHAN];  // line r-1
   logic signed [CS_W-1:0]    col_sum_prev [2][NCHAN];             // columns c-1, c-2
   int unsigned               pos_col;
   int unsigned               pos_row;

   pixel_result_type  expected_pixels [$];
   known_outcome_type pending_outcome [$];   // one per pixel offered, popped on transfer
   stim_row_type      directed_rows [$];
   int                mismatch_count = 0;
   int                send_idle_pct;
   int                recv_idle_pct;

   function automatic pixel_result_type flat_pixel(logic [PIX_W-1:0] v, int col, int row,
                                                   logic last);
      pixel_result_type p;
      p.red   = v;
      p.green = v;
      p.blue  = v;
      p.col   = OUT_COL_W'(col);
      p.row   = OUT_ROW_W'(row);
      p.last  = last;
      return p;
   endfunction

   // sizes below three act as three, above the build limit as the limit
   function automatic int unsigned eff_size(int unsigned v, int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void restart_frame();
      col_sum_prev = '{default: '0};
      pos_col      = 0;
      pos_row      = 0;
   endfunction

   // A register write lands at once and restarts the frame
   function automatic void apply_frame_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_FRAME_WIDTH:  pred_width  = d[FRAME_WIDTH_W-1:0];
         CSR_FRAME_HEIGHT: pred_height = d[FRAME_HEIGHT_W-1:0];
         default: ;
      endcase
      restart_frame();
   endfunction

   // Works out the 0..3 results one pixel causes and advances the state.
   // Order: left border zero, window, right border zero, bottom border zero.
   function automatic int predict_box_sum(pix_pair_type px,
                                          output pixel_result_type [2:0] res);
      int unsigned      w, h, c, r;
      int               n;
      int               nv [NCHAN];
      int               ov [NCHAN];
      int               d [NCHAN];
      int               cs [NCHAN];
      int               win;
      logic [PIX_W-1:0] scaled [NCHAN];

      w  = eff_size(pred_width, DEF_MAX_WIDTH);
      h  = eff_size(pred_height, DEF_MAX_HEIGHT);
      c  = pos_col;
      r  = pos_row;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      nv = '{int'(px.new_red), int'(px.new_green), int'(px.new_blue)};
      ov = '{int'(px.old_red), int'(px.old_green), int'(px.old_blue)};
      for (int ch = 0; ch < NCHAN; ch++) begin
         d[ch]      = nv[ch] - ov[ch];
         cs[ch]     = int'(diff_two_up[c][ch]) + int'(diff_one_up[c][ch]) + d[ch];
         win        = cs[ch] + int'(col_sum_prev[0][ch]) + int'(col_sum_prev[1][ch]);
         scaled[ch] = PIX_W'((win + BOX_BIAS) / BOX_DIV);
      end

      res = '0;
      n   = 0;
      if (r == 0) begin
         res[n] = flat_pixel(8'd0, int'(c), 0, 1'b0);
         n++;
      end else if (r >= 2) begin
         if (c == 1) begin
            res[n] = flat_pixel(8'd0, 0, int'(r) - 1, 1'b0);
            n++;
         end
         if (c >= 2) begin
            res[n]       = flat_pixel(8'd0, int'(c) - 1, int'(r) - 1, 1'b0);
            res[n].red   = scaled[0];
            res[n].green = scaled[1];
            res[n].blue  = scaled[2];
            n++;
         end
         if (c == w - 1) begin
            res[n] = flat_pixel(8'd0, int'(w) - 1, int'(r) - 1, 1'b0);
            n++;
         end
         if (r == h - 1) begin
            res[n] = flat_pixel(8'd0, int'(c), int'(r), 1'b0);
            n++;
         end
      end
      if (n > 0) res[n-1].last = 1'b1;

      for (int ch = 0; ch < NCHAN; ch++) begin
         col_sum_prev[1][ch] = col_sum_prev[0][ch];
         col_sum_prev[0][ch] = CS_W'(cs[ch]);
         diff_two_up[c][ch]  = diff_one_up[c][ch];
         diff_one_up[c][ch]  = DIFF_W'(d[ch]);
      end

      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      pos_col = c;
      pos_row = r;
      return n;
   endfunction

   task automatic report_mismatch(string what, pixel_result_type got,
                                  pixel_result_type want);
      mismatch_count++;
      $display({"%0t %s: got %0d/%0d/%0d at (%0d,%0d) last %0b, ",
                "expected %0d/%0d/%0d at (%0d,%0d) last %0b"},
               $time, what, got.red, got.green, got.blue, got.col, got.row, got.last,
               want.red, want.green, want.blue, want.col, want.row, want.last);
   endtask

   // ---------------------------------------------------------------------
   // Scoreboard: sampled at the rising edge, so it sees what the block saw.
   // Expectations are pushed before results are popped in the same edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      pix_pair_type           px_in;
      pixel_result_type [2:0] fresh;
      pixel_result_type       got;
      pixel_result_type       want;
      known_outcome_type      outcome;
      int                     n;

      if (reset) begin
         pred_width  = FRAME_WIDTH_W'(FRAME_WIDTH_RST);
         pred_height = FRAME_HEIGHT_W'(FRAME_HEIGHT_RST);
         diff_two_up = '{default: '0};
         diff_one_up = '{default: '0};
         restart_frame();
      end else begin
         if (csr_we) apply_frame_csr(csr_index, csr_wdata);

         if (req_chan.valid && req_chan.ready) begin
            px_in.new_red   = req_chan.new_red;
            px_in.new_green = req_chan.new_green;
            px_in.new_blue  = req_chan.new_blue;
            px_in.old_red   = req_chan.old_red;
            px_in.old_green = req_chan.old_green;
            px_in.old_blue  = req_chan.old_blue;
            // predictor always runs so its state stays in step with the block
            n       = predict_box_sum(px_in, fresh);
            outcome = pending_outcome.pop_front();
            if (outcome.typed) begin
               for (int i = 0; i < int'(outcome.count); i++)
                  expected_pixels.push_back(outcome.res[i]);
            end else begin
               for (int i = 0; i < n; i++)
                  expected_pixels.push_back(fresh[i]);
            end
         end

         if (rsp_chan.valid && rsp_chan.ready) begin
            got.red   = rsp_chan.out_red;
            got.green = rsp_chan.out_green;
            got.blue  = rsp_chan.out_blue;
            got.col   = rsp_chan.out_col;
            got.row   = rsp_chan.out_row;
            got.last  = rsp_chan.run_last;
            if (expected_pixels.size() == 0) begin
               report_mismatch("result with nothing expected", got, NO_PIXEL);
            end else begin
               want = expected_pixels.pop_front();
               if (got.red   !== want.red)   report_mismatch("out_red", got, want);
               if (got.green !== want.green) report_mismatch("out_green", got, want);
               if (got.blue  !== want.blue)  report_mismatch("out_blue", got, want);
               if (got.col   !== want.col)   report_mismatch("out_col", got, want);
               if (got.row   !== want.row)   report_mismatch("out_row", got, want);
               if (got.last  !== want.last)  report_mismatch("run_last", got, want);
            end
         end
      end
   end

   // Result side back-pressure, redrawn every cycle
   initial begin : result_sink
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Hang guard
   initial begin : watchdog
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("timeout after %0d cycles, %0d results outstanding",
               LIMIT_CYCLES, expected_pixels.size());
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic void add_pixel(pix_pair_type px);
      stim_row_type row;
      row      = '0;
      row.kind = ROW_PIXEL;
      row.px   = px;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_known(pix_pair_type px, int count, pixel_result_type r0,
                                     pixel_result_type r1, pixel_result_type r2);
      stim_row_type row;
      row               = '0;
      row.kind          = ROW_PIXEL;
      row.px            = px;
      row.outcome.typed = 1'b1;
      row.outcome.count = 2'(count);
      row.outcome.res   = {r2, r1, r0};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] d);
      stim_row_type row;
      row          = '0;
      row.kind     = ROW_CSR;
      row.csr_idx  = idx;
      row.csr_data = d;
      directed_rows.push_back(row);
   endfunction

   // Called at a rising edge. Drops valid, then waits for the scoreboard to
   // empty (polled at the falling edge, clear of the rising-edge updates) and
   // lets the result path settle, since row one pixels leave nothing behind.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(negedge clock);
      while (expected_pixels.size() != 0 || pending_outcome.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] d);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Random gap, then hold the pixel until its transfer. Valid is left high;
   // the next call or a drain decides in this same step whether it drops.
   task automatic send_pixel(pix_pair_type px, known_outcome_type outcome);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      pending_outcome.push_back(outcome);
      req_chan.valid     <= 1'b1;
      req_chan.new_red   <= px.new_red;
      req_chan.new_green <= px.new_green;
      req_chan.new_blue  <= px.new_blue;
      req_chan.old_red   <= px.old_red;
      req_chan.old_green <= px.old_green;
      req_chan.old_blue  <= px.old_blue;
      do @(posedge clock);
      while (!req_chan.ready);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      pix_pair_type     px;
      pix_pair_type     frame_px;
      logic [PIX_W-1:0] flat_val;
      int               mode;
      int               pause_at;

      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_FRAME_WIDTH;
      csr_wdata          <= '0;
      req_chan.valid     <= 1'b0;
      req_chan.new_red   <= '0;
      req_chan.new_green <= '0;
      req_chan.new_blue  <= '0;
      req_chan.old_red   <= '0;
      req_chan.old_green <= '0;
      req_chan.old_blue  <= '0;
      send_idle_pct       = SEND_IDLE[0];
      recv_idle_pct       = RECV_IDLE[0];

      // --- directed table ---
      // at reset size 640x480 the top row only gives border zeros
      add_known(PX_RISE, 1, flat_pixel(8'd0, 0, 0, 1'b1), NO_PIXEL, NO_PIXEL);
      add_known(PX_FALL, 1, flat_pixel(8'd0, 1, 0, 1'b1), NO_PIXEL, NO_PIXEL);
      // smallest frame; a height below three acts as three
      add_csr(CSR_FRAME_WIDTH, CSR_DATA_W'(3));
      add_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'(2));
      // two 3x3 frames back to back: full positive difference then full
      // negative, so the lone window saturates high, then low
      for (int f = 0; f < 2; f++) begin
         frame_px = (f == 0) ? PX_RISE : PX_FALL;
         flat_val = (f == 0) ? 8'd255 : 8'd0;
         for (int c = 0; c < 3; c++)
            add_known(frame_px, 1, flat_pixel(8'd0, c, 0, 1'b1), NO_PIXEL, NO_PIXEL);
         for (int c = 0; c < 3; c++)
            add_known(frame_px, 0, NO_PIXEL, NO_PIXEL, NO_PIXEL);
         add_known(frame_px, 1, flat_pixel(8'd0, 0, 2, 1'b1), NO_PIXEL, NO_PIXEL);
         add_known(frame_px, 2, flat_pixel(8'd0, 0, 1, 1'b0),
                   flat_pixel(8'd0, 1, 2, 1'b1), NO_PIXEL);
         add_known(frame_px, 3, flat_pixel(flat_val, 1, 1, 1'b0),
                   flat_pixel(8'd0, 2, 1, 1'b0), flat_pixel(8'd0, 2, 2, 1'b1));
      end
      // oversize: width field truncates to 4095 and clamps, height at its limit
      add_csr(CSR_FRAME_WIDTH, 13'h1FFF);
      add_csr(CSR_FRAME_HEIGHT, 13'h1000);
      add_pixel({8'h55, 8'hAA, 8'h0F, 8'hAA, 8'h55, 8'hF0});
      add_pixel({8'h80, 8'h7F, 8'h01, 8'h7F, 8'h80, 8'hFE});
      add_pixel({8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33});
      add_pixel(PX_RISE);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_CSR)
            write_frame_csr(directed_rows[k].csr_idx, directed_rows[k].csr_data);
         else
            send_pixel(directed_rows[k].px, directed_rows[k].outcome);
      end

      // --- random frames, one size setting per idling phase ---
      for (int phase = 0; phase < 3; phase++) begin
         write_frame_csr(CSR_FRAME_WIDTH, CSR_DATA_W'($urandom_range(3, 9)));
         write_frame_csr(CSR_FRAME_HEIGHT, CSR_DATA_W'($urandom_range(3, 7)));
         send_idle_pct = SEND_IDLE[phase];
         recv_idle_pct = RECV_IDLE[phase];
         pause_at      = $urandom_range(8, 25);
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            mode = $urandom_range(0, 9);
            px   = {$urandom(), 16'($urandom())};
            case (mode)
               6: px = PX_RISE;
               7: px = PX_FALL;
               8: begin   // static scene
                  px.old_red   = px.new_red;
                  px.old_green = px.new_green;
                  px.old_blue  = px.new_blue;
               end
               9: begin   // sensor noise only
                  px.old_red   = px.new_red ^ 8'($urandom_range(0, 3));
                  px.old_green = px.new_green ^ 8'($urandom_range(0, 3));
                  px.old_blue  = px.new_blue ^ 8'($urandom_range(0, 3));
               end
               default: ;
            endcase
            send_pixel(px, '0);
            // hold the source back once until the block has drained
            if (phase == 1 && i == pause_at) wait_for_results();
         end
      end

      wait_for_results();
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
